// ----- src/damped_comb_allpass_reverb_defines.svh -----
// Assertion macros used by the reverb top level.
`ifndef DAMPED_COMB_ALLPASS_REVERB_DEFINES_SVH
`define DAMPED_COMB_ALLPASS_REVERB_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define DCAR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("reverb assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define DCAR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("reverb assertion failed");

`endif

// ----- src/dcar_pkg.sv -----
// Package: types, constants and arithmetic helpers of the reverb.
`default_nettype none
package dcar_pkg;
    localparam int SAMPLE_RATE_DEF = 44100;
    localparam int REF_RATE        = 44100;
    localparam int MIN_LEN         = 10;
    localparam int SW              = 24;
    localparam int NCOMB           = 8;
    localparam int NAP             = 4;

    localparam int COMB_TAP [NCOMB] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
    localparam int AP_TAP [NAP]     = '{556, 441, 341, 225};

    typedef logic signed [SW-1:0] t_sample;
    typedef logic signed [47:0]   t_wide;

    localparam t_wide W_MAX = 48'sh7FFFFF;
    localparam t_wide W_MIN = -48'sh800000;

    // coefficient constants (Q0.16)
    localparam int ONE16      = 65536;
    localparam int TWO17      = 131072;
    localparam int ROUND16    = 32768;
    localparam int ROUND17    = 65536;
    localparam int FB_BASE    = 18350;
    localparam int FB_SCALE   = 45875;
    localparam int DAMP_SCALE = 26214;

    // register indexes
    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_ROOM   = 3'd0;
    localparam t_reg_idx REG_DAMP   = 3'd1;
    localparam t_reg_idx REG_WET    = 3'd2;
    localparam t_reg_idx REG_DRY    = 3'd3;
    localparam t_reg_idx REG_WIDTH  = 3'd4;
    localparam t_reg_idx REG_GAIN   = 3'd5;
    localparam t_reg_idx REG_STEREO = 3'd6;

    // sequencer steps
    typedef logic [4:0] t_step;
    localparam t_step STEP_COMB_RD = 5'd0;
    localparam t_step STEP_COMB_M1 = 5'd1;
    localparam t_step STEP_COMB_M2 = 5'd2;
    localparam t_step STEP_SUM     = 5'd2;
    localparam t_step STEP_COMB_LP = 5'd3;
    localparam t_step STEP_Y       = 5'd3;
    localparam t_step STEP_COMB_M3 = 5'd4;
    localparam t_step STEP_AP_RD0  = 5'd4;
    localparam t_step STEP_AP_RD3  = 5'd7;
    localparam t_step STEP_COMB_WR = 5'd5;
    localparam t_step STEP_AP_WR0  = 5'd5;
    localparam t_step STEP_AP_WR3  = 5'd8;
    localparam t_step STEP_MIX_GN  = 5'd9;
    localparam t_step STEP_MIX_REV = 5'd10;
    localparam t_step STEP_MIX_LD  = 5'd11;
    localparam t_step STEP_MIX_LW  = 5'd12;
    localparam t_step STEP_MIX_LO  = 5'd13;
    localparam t_step STEP_MIX_RW  = 5'd14;
    localparam t_step STEP_MIX_RO  = 5'd15;
    localparam t_step STEP_LAST    = 5'd16;

    typedef struct packed {
        logic  run;
        logic  clr;
        t_step step;
    } t_seq;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RUN} t_state;

    // delay length scaled to the sample rate
    function automatic int dlen(int tap, int rate);
        int v;
        v = (tap * rate) / REF_RATE;
        return (v < MIN_LEN) ? MIN_LEN : v;
    endfunction

    // round half up, then shift right
    function automatic t_wide rnd(t_wide v, int unsigned s);
        return (v + (t_wide'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic t_sample sat(t_wide v);
        t_wide c;
        c = (v > W_MAX) ? W_MAX : ((v < W_MIN) ? W_MIN : v);
        return c[SW-1:0];
    endfunction

    function automatic logic [16:0] clamp1(logic [16:0] v);
        return (v > 17'(ONE16)) ? 17'(ONE16) : v;
    endfunction
endpackage
`default_nettype wire

// ----- src/dcar_if.sv -----
// Frame channels: input and output words with valid/ready.
`default_nettype none
interface dcar_in_if;
    logic              valid;
    logic              ready;
    dcar_pkg::t_sample left_sample;
    dcar_pkg::t_sample right_sample;
    modport source (output valid, left_sample, right_sample, input ready);
    modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface dcar_out_if;
    logic              valid;
    logic              ready;
    dcar_pkg::t_sample left_out;
    dcar_pkg::t_sample right_out;
    modport source (output valid, left_out, right_out, input ready);
    modport sink   (input valid, left_out, right_out, output ready);
endinterface
`default_nettype wire

// ----- src/dcar_comb_lane.sv -----
// One damped feedback comb: delay memory, lowpass state and position.
`default_nettype none
module dcar_comb_lane #(
    parameter int LEN = 1116,
    parameter int CW  = 11
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dcar_pkg::t_seq    i_seq,
    input  wire logic [CW-1:0]     i_clr_addr,
    input  wire dcar_pkg::t_sample i_x,
    input  wire logic [16:0]       i_omd,
    input  wire logic [14:0]       i_d,
    input  wire logic [15:0]       i_fb,
    output dcar_pkg::t_sample      o_tap
);
    localparam int AW = $clog2(LEN);

    dcar_pkg::t_sample r_mem [LEN];
    logic [AW-1:0]     r_pos, n_pos;
    dcar_pkg::t_sample r_lp;
    dcar_pkg::t_sample r_o;
    logic signed [41:0] r_m1, r_m2, r_m3;

    logic signed [41:0] w_m1, w_m2, w_m3;
    dcar_pkg::t_sample  w_lp, w_wr;
    logic               w_clr_hit;

    // products and rounding
    always_comb begin
        w_m1 = r_o * $signed({1'b0, i_omd});
        w_m2 = r_lp * $signed({1'b0, i_d});
        w_m3 = r_lp * $signed({1'b0, i_fb});
        w_lp = dcar_pkg::sat(dcar_pkg::rnd(dcar_pkg::t_wide'(r_m1)
                                         + dcar_pkg::t_wide'(r_m2), 16));
        w_wr = dcar_pkg::sat(dcar_pkg::t_wide'(i_x)
                           + dcar_pkg::rnd(dcar_pkg::t_wide'(r_m3), 16));
        n_pos = (r_pos == AW'(LEN - 1)) ? '0 : r_pos + 1'b1;
        w_clr_hit = i_seq.clr && (i_clr_addr < CW'(LEN));
    end

    // delay memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_clr_hit) begin
            r_mem[i_clr_addr[AW-1:0]] <= '0;
        end else if (i_seq.run && i_seq.step == dcar_pkg::STEP_COMB_WR) begin
            r_mem[r_pos] <= w_wr;
        end
        if (i_seq.run && i_seq.step == dcar_pkg::STEP_COMB_RD) begin
            r_o <= r_mem[r_pos];
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_seq.run && i_seq.step == dcar_pkg::STEP_COMB_M1) r_m1 <= w_m1;
        if (i_seq.run && i_seq.step == dcar_pkg::STEP_COMB_M2) r_m2 <= w_m2;
        if (i_seq.run && i_seq.step == dcar_pkg::STEP_COMB_M3) r_m3 <= w_m3;
    end

    // lowpass state and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_lp  <= '0;
        end else if (i_seq.run) begin
            if (i_seq.step == dcar_pkg::STEP_COMB_LP) r_lp <= w_lp;
            if (i_seq.step == dcar_pkg::STEP_COMB_WR) r_pos <= n_pos;
        end
    end

    assign o_tap = r_o;
endmodule
`default_nettype wire

// ----- src/dcar_ap_merge.sv -----
// Merge of the comb lanes: sum, scale and four series allpasses.
`default_nettype none
module dcar_ap_merge #(
    parameter int SAMPLE_RATE = dcar_pkg::SAMPLE_RATE_DEF,
    parameter int CW          = 11
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dcar_pkg::t_seq    i_seq,
    input  wire logic [CW-1:0]     i_clr_addr,
    input  wire dcar_pkg::t_sample i_taps [dcar_pkg::NCOMB],
    output dcar_pkg::t_sample      o_y
);
    localparam int AP_LEN [dcar_pkg::NAP] = '{
        dcar_pkg::dlen(dcar_pkg::AP_TAP[0], SAMPLE_RATE),
        dcar_pkg::dlen(dcar_pkg::AP_TAP[1], SAMPLE_RATE),
        dcar_pkg::dlen(dcar_pkg::AP_TAP[2], SAMPLE_RATE),
        dcar_pkg::dlen(dcar_pkg::AP_TAP[3], SAMPLE_RATE)};
    localparam int AP_BASE [dcar_pkg::NAP] = '{
        0, AP_LEN[0], AP_LEN[0] + AP_LEN[1], AP_LEN[0] + AP_LEN[1] + AP_LEN[2]};
    localparam int AP_TOTAL = AP_LEN[0] + AP_LEN[1] + AP_LEN[2] + AP_LEN[3];
    localparam int AAW = $clog2(AP_TOTAL);

    dcar_pkg::t_sample r_mem [AP_TOTAL];
    logic [AAW-1:0]    r_pos [dcar_pkg::NAP];
    logic signed [26:0] r_sum;
    dcar_pkg::t_sample r_y;
    dcar_pkg::t_sample r_b;

    logic signed [26:0] w_sum;
    logic [1:0]         w_ri, w_wi;
    dcar_pkg::t_step    w_wstep;
    logic [AAW-1:0]     w_raddr, w_waddr, w_pos_nx;
    logic               w_rd, w_wr, w_clr_hit;

    // comb tap sum and allpass addressing
    always_comb begin
        w_sum = '0;
        for (int k = 0; k < dcar_pkg::NCOMB; k++) begin
            w_sum = w_sum + 27'(i_taps[k]);
        end
        w_ri    = i_seq.step[1:0];
        w_wstep = i_seq.step + 5'd3;
        w_wi    = w_wstep[1:0];
        w_raddr = AAW'(AP_BASE[w_ri]) + r_pos[w_ri];
        w_waddr = AAW'(AP_BASE[w_wi]) + r_pos[w_wi];
        w_pos_nx = (r_pos[w_wi] == AAW'(AP_LEN[w_wi] - 1)) ? '0 : r_pos[w_wi] + 1'b1;
        w_rd = i_seq.run && i_seq.step >= dcar_pkg::STEP_AP_RD0
                         && i_seq.step <= dcar_pkg::STEP_AP_RD3;
        w_wr = i_seq.run && i_seq.step >= dcar_pkg::STEP_AP_WR0
                         && i_seq.step <= dcar_pkg::STEP_AP_WR3;
        w_clr_hit = i_seq.clr && (i_clr_addr < CW'(AP_TOTAL));
    end

    // allpass memory
    always_ff @(posedge i_clk) begin
        if (w_clr_hit) begin
            r_mem[i_clr_addr[AAW-1:0]] <= '0;
        end else if (w_wr) begin
            r_mem[w_waddr] <= dcar_pkg::sat(dcar_pkg::t_wide'(r_y)
                                + dcar_pkg::rnd(dcar_pkg::t_wide'(r_b), 1));
        end
        if (w_rd) r_b <= r_mem[w_raddr];
    end

    // running sample through the chain
    always_ff @(posedge i_clk) begin
        if (i_seq.run && i_seq.step == dcar_pkg::STEP_SUM) r_sum <= w_sum;
        if (i_seq.run && i_seq.step == dcar_pkg::STEP_Y) begin
            r_y <= dcar_pkg::sat(dcar_pkg::rnd(dcar_pkg::t_wide'(r_sum), 2));
        end else if (w_wr) begin
            r_y <= dcar_pkg::sat(dcar_pkg::t_wide'(r_b) - dcar_pkg::t_wide'(r_y));
        end
    end

    // positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < dcar_pkg::NAP; k++) r_pos[k] <= '0;
        end else if (w_wr) begin
            r_pos[w_wi] <= w_pos_nx;
        end
    end

    assign o_y = r_y;
endmodule
`default_nettype wire

// ----- src/dcar_mix.sv -----
// Output gain and dry/wet mixing on one shared multiplier.
`default_nettype none
module dcar_mix (
    input  wire logic              i_clk,
    input  wire dcar_pkg::t_seq    i_seq,
    input  wire dcar_pkg::t_sample i_y,
    input  wire dcar_pkg::t_sample i_l,
    input  wire dcar_pkg::t_sample i_r,
    input  wire logic              i_stereo,
    input  wire logic [15:0]       i_gain,
    input  wire logic [16:0]       i_dry,
    input  wire logic [16:0]       i_cw,
    input  wire logic [16:0]       i_w2,
    output dcar_pkg::t_sample      o_left,
    output dcar_pkg::t_sample      o_right
);
    dcar_pkg::t_sample  w_a;
    logic [16:0]        w_b;
    logic signed [41:0] w_prod;
    dcar_pkg::t_wide    w_mix;
    logic signed [41:0] r_prod, r_acc;
    dcar_pkg::t_sample  r_rev, r_ol, r_or;

    // operand select per step
    always_comb begin
        unique case (i_seq.step)
            dcar_pkg::STEP_MIX_GN: begin w_a = i_y;   w_b = {1'b0, i_gain}; end
            dcar_pkg::STEP_MIX_LD: begin w_a = i_l;   w_b = i_dry; end
            dcar_pkg::STEP_MIX_LW: begin w_a = r_rev; w_b = i_cw; end
            dcar_pkg::STEP_MIX_LO: begin w_a = i_r;   w_b = i_dry; end
            dcar_pkg::STEP_MIX_RW: begin w_a = r_rev; w_b = i_w2; end
            default:               begin w_a = i_y;   w_b = i_dry; end
        endcase
        w_prod = w_a * $signed({1'b0, w_b});
        w_mix  = dcar_pkg::rnd(dcar_pkg::t_wide'(r_acc) + dcar_pkg::t_wide'(r_prod), 16);
    end

    // product pipeline
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (i_seq.run) begin
            if (i_seq.step == dcar_pkg::STEP_MIX_REV) begin
                r_rev <= dcar_pkg::sat(dcar_pkg::rnd(dcar_pkg::t_wide'(r_prod), 14));
            end
            if (i_seq.step == dcar_pkg::STEP_MIX_LW || i_seq.step == dcar_pkg::STEP_MIX_RW) begin
                r_acc <= r_prod;
            end
            if (i_seq.step == dcar_pkg::STEP_MIX_LO) r_ol <= dcar_pkg::sat(w_mix);
            if (i_seq.step == dcar_pkg::STEP_MIX_RO) begin
                r_or <= i_stereo ? dcar_pkg::sat(w_mix) : '0;
            end
        end
    end

    assign o_left  = r_ol;
    assign o_right = r_or;
endmodule
`default_nettype wire

// ----- src/damped_comb_allpass_reverb.sv -----
// Top level of the damped comb / allpass reverb.
`default_nettype none
`include "damped_comb_allpass_reverb_defines.svh"
// Stereo reverb on Q1.23 frames: one frame in, one frame out. Eight comb lanes
// run side by side, each with its own delay memory; a merge stage sums them and
// walks four series allpasses in one shared memory, and a mixer applies gain and
// the dry/wet mix. Each frame is walked through by the step sequencer (sixteen
// work steps, dominated by the allpass chain and the shared mixing multiplier).
// The output register lets the next frame be accepted while a result still
// waits. After reset a clearing pass zeroes all delay memories, one entry per
// cycle, over the longer of the longest comb and the whole allpass memory; no
// frame is accepted during it. Configuration writes are taken at any time but
// are meant for idle periods.
module damped_comb_allpass_reverb #(
    parameter int SAMPLE_RATE = dcar_pkg::SAMPLE_RATE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    dcar_in_if.sink          i_in,
    dcar_out_if.source       o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [16:0] i_cfg_wdata
);
    localparam int COMB_MAX = dcar_pkg::dlen(dcar_pkg::COMB_TAP[dcar_pkg::NCOMB-1],
                                             SAMPLE_RATE);
    localparam int AP_SUM = dcar_pkg::dlen(dcar_pkg::AP_TAP[0], SAMPLE_RATE)
                          + dcar_pkg::dlen(dcar_pkg::AP_TAP[1], SAMPLE_RATE)
                          + dcar_pkg::dlen(dcar_pkg::AP_TAP[2], SAMPLE_RATE)
                          + dcar_pkg::dlen(dcar_pkg::AP_TAP[3], SAMPLE_RATE);
    localparam int CLR_LEN = (COMB_MAX > AP_SUM) ? COMB_MAX : AP_SUM;
    localparam int CW = $clog2(CLR_LEN + 1);

    // configuration registers
    logic [16:0] r_room, r_damp, r_wet, r_dry, r_width;
    logic [15:0] r_gain;
    logic        r_stereo;

    // derived coefficients
    logic [15:0] r_fb;
    logic [14:0] r_d;
    logic [16:0] r_omd, r_w1, r_w2, r_cw;
    logic [33:0] w_fbp, w_dp;
    logic [35:0] w_w1p, w_w2p;
    logic [16:0] w_room, w_damp, w_wet, w_width;

    // sequencer
    dcar_pkg::t_state r_state, n_state;
    dcar_pkg::t_step  r_step, n_step;
    logic [CW-1:0]    r_clr_cnt, n_clr_cnt;
    logic             r_ovalid, n_ovalid;
    logic             w_accept, w_load;
    dcar_pkg::t_seq   w_seq;

    // frame and result registers
    dcar_pkg::t_sample r_l, r_r, r_x, r_ol, r_or;
    dcar_pkg::t_sample w_x, w_y, w_ml, w_mr;
    dcar_pkg::t_sample w_taps [dcar_pkg::NCOMB];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_room   <= 17'd32768;
            r_damp   <= 17'd32768;
            r_wet    <= 17'd21627;
            r_dry    <= 17'd0;
            r_width  <= 17'd65536;
            r_gain   <= 16'd14746;
            r_stereo <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dcar_pkg::REG_ROOM:   r_room   <= i_cfg_wdata;
                dcar_pkg::REG_DAMP:   r_damp   <= i_cfg_wdata;
                dcar_pkg::REG_WET:    r_wet    <= i_cfg_wdata;
                dcar_pkg::REG_DRY:    r_dry    <= i_cfg_wdata;
                dcar_pkg::REG_WIDTH:  r_width  <= i_cfg_wdata;
                dcar_pkg::REG_GAIN:   r_gain   <= i_cfg_wdata[15:0];
                dcar_pkg::REG_STEREO: r_stereo <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // coefficient products
    always_comb begin
        w_room  = dcar_pkg::clamp1(r_room);
        w_damp  = dcar_pkg::clamp1(r_damp);
        w_wet   = dcar_pkg::clamp1(r_wet);
        w_width = dcar_pkg::clamp1(r_width);
        w_fbp = 34'(dcar_pkg::FB_SCALE) * 34'(w_room) + 34'(dcar_pkg::ROUND16);
        w_dp  = 34'(dcar_pkg::DAMP_SCALE) * 34'(w_damp) + 34'(dcar_pkg::ROUND16);
        w_w1p = 36'(w_wet) * 36'(18'(dcar_pkg::TWO17) + 18'(w_width))
              + 36'(dcar_pkg::ROUND17);
        w_w2p = 36'(w_wet) * 36'(18'(dcar_pkg::TWO17) - 18'(w_width))
              + 36'(dcar_pkg::ROUND17);
    end

    always_ff @(posedge i_clk) begin
        r_fb  <= 16'(dcar_pkg::FB_BASE) + w_fbp[31:16];
        r_d   <= w_dp[30:16];
        r_omd <= 17'(dcar_pkg::ONE16) - 17'(w_dp[30:16]);
        r_w1  <= w_w1p[33:17];
        r_w2  <= w_w2p[33:17];
        r_cw  <= r_stereo ? r_w1 : dcar_pkg::clamp1(r_wet);
    end

    // handshake
    assign i_in.ready = (r_state == dcar_pkg::ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_load     = (r_state == dcar_pkg::ST_RUN) && (r_step == dcar_pkg::STEP_LAST)
                        && (!r_ovalid || o_out.ready);

    // next state
    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_clr_cnt = r_clr_cnt;
        n_ovalid  = r_ovalid && !o_out.ready;
        unique case (r_state)
            dcar_pkg::ST_CLEAR: begin
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == CW'(CLR_LEN - 1)) n_state = dcar_pkg::ST_IDLE;
            end
            dcar_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = dcar_pkg::ST_RUN;
                    n_step  = dcar_pkg::STEP_COMB_RD;
                end
            end
            dcar_pkg::ST_RUN: begin
                if (r_step != dcar_pkg::STEP_LAST) begin
                    n_step = r_step + 1'b1;
                end else if (w_load) begin
                    n_state  = dcar_pkg::ST_IDLE;
                    n_ovalid = 1'b1;
                end
            end
            default: n_state = dcar_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dcar_pkg::ST_CLEAR;
            r_step    <= '0;
            r_clr_cnt <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_clr_cnt <= n_clr_cnt;
            r_ovalid  <= n_ovalid;
        end
    end

    // input frame and mono feed
    assign w_x = r_stereo ? dcar_pkg::sat(dcar_pkg::rnd(dcar_pkg::t_wide'(i_in.left_sample)
                            + dcar_pkg::t_wide'(i_in.right_sample), 1))
                          : i_in.left_sample;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_l <= i_in.left_sample;
            r_r <= i_in.right_sample;
            r_x <= w_x;
        end
        if (w_load) begin
            r_ol <= w_ml;
            r_or <= w_mr;
        end
    end

    assign w_seq.run  = (r_state == dcar_pkg::ST_RUN);
    assign w_seq.clr  = (r_state == dcar_pkg::ST_CLEAR);
    assign w_seq.step = r_step;

    // comb lanes
    for (genvar g = 0; g < dcar_pkg::NCOMB; g++) begin : g_comb
        dcar_comb_lane #(
            .LEN (dcar_pkg::dlen(dcar_pkg::COMB_TAP[g], SAMPLE_RATE)),
            .CW  (CW)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_seq      (w_seq),
            .i_clr_addr (r_clr_cnt),
            .i_x        (r_x),
            .i_omd      (r_omd),
            .i_d        (r_d),
            .i_fb       (r_fb),
            .o_tap      (w_taps[g])
        );
    end

    dcar_ap_merge #(
        .SAMPLE_RATE (SAMPLE_RATE),
        .CW          (CW)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_seq      (w_seq),
        .i_clr_addr (r_clr_cnt),
        .i_taps     (w_taps),
        .o_y        (w_y)
    );

    dcar_mix u_mix (
        .i_clk    (i_clk),
        .i_seq    (w_seq),
        .i_y      (w_y),
        .i_l      (r_l),
        .i_r      (r_r),
        .i_stereo (r_stereo),
        .i_gain   (r_gain),
        .i_dry    (dcar_pkg::clamp1(r_dry)),
        .i_cw     (r_cw),
        .i_w2     (r_w2),
        .o_left   (w_ml),
        .o_right  (w_mr)
    );

    assign o_out.valid     = r_ovalid;
    assign o_out.left_out  = r_ol;
    assign o_out.right_out = r_or;

    // checks
    `DCAR_ASSERT_NXT(a_accept_starts, w_accept,
        r_state == dcar_pkg::ST_RUN && r_step == dcar_pkg::STEP_COMB_RD)
    `DCAR_ASSERT_IMP(a_step_bound, r_state == dcar_pkg::ST_RUN,
        r_step <= dcar_pkg::STEP_LAST)
    `DCAR_ASSERT_NXT(a_clear_ends, r_state == dcar_pkg::ST_CLEAR && r_clr_cnt == CW'(CLR_LEN - 1),
        r_state == dcar_pkg::ST_IDLE)
    `DCAR_ASSERT_NXT(a_load_valid, w_load, o_out.valid)
endmodule
`default_nettype wire
